### hdl/scheduled_pwm_fader_assert.svh
// Assertion macros for the scheduled PWM fader.
// Included by the top level; expects signals named clk and rst_n in scope.
`ifndef SCHEDULED_PWM_FADER_ASSERT_SVH
`define SCHEDULED_PWM_FADER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define SPF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### hdl/spf_pkg.sv
// Shared types and constants for the scheduled PWM fader.
// Used by spf_div, spf_seq and scheduled_pwm_fader; depends on nothing.
package spf_pkg;

    localparam int MAX_EVENTS = 4;
    localparam int EV_IDX_W   = 2;
    localparam int EV_CNT_W   = 3;
    localparam int EVENT_W    = 42;

    localparam logic [17:0] DAY_SECONDS = 18'd86400;
    localparam logic [9:0]  MS_PER_S    = 10'd1000;
    localparam logic [7:0]  LEVEL_MAX   = 8'd255;

    // Shared divider: 36-bit dividend, 28-bit divisor, one quotient bit a cycle.
    localparam int DIVIDEND_W = 36;
    localparam int DIVISOR_W  = 28;
    localparam int DIV_CNT_W  = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

    typedef enum logic [2:0] {
        REG_DAYS_MASK     = 3'd0,
        REG_EVENT_COUNT   = 3'd1,
        REG_HAS_DEPENDENT = 3'd2,
        REG_SUSPEND       = 3'd3,
        REG_EVENT_0       = 3'd4,
        REG_EVENT_1       = 3'd5,
        REG_EVENT_2       = 3'd6,
        REG_EVENT_3       = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV_INT,
        ST_CHECK,
        ST_MUL,
        ST_DIV_LVL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [6:0]                           days_mask;
        logic [EV_CNT_W-1:0]                  event_count;
        logic                                 has_dependent;
        logic                                 suspend;
        logic [MAX_EVENTS-1:0][EVENT_W-1:0]   events;
    } cfg_t;

    typedef struct packed {
        logic        dependent_on;
        logic [31:0] millis_now;
        logic [16:0] time_of_day;
        logic [2:0]  weekday;
    } item_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] pwm_level;
        logic       level_written;
        logic       output_active;
    } res_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

### hdl/scheduled_pwm_fader.sv
// Scheduled PWM fader: top level with stream ports, register file and result register.
// Depends on spf_pkg, spf_seq, spf_div and the assertion header.
//
// One request carries a tick and yields exactly one result. The block takes a
// request only while its sequencer is idle. An event that needs no division is
// handled in ST_EVAL alone. An event whose fade is checked for a step but takes
// none or has run past its span goes through the step-interval division
// (ST_DIV_INT) and ST_CHECK. An event that steps the level also goes through
// ST_MUL and the fade-fraction division (ST_DIV_LVL). Both divisions use the
// single shared divider. The result then waits in ST_DONE until the output
// register is free to take it. The finished result sits in an output register,
// so the next request is taken while it waits.
module scheduled_pwm_fader (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // weekday[2:0], time_of_day[19:3], millis_now[51:20],
                                   // dependent_on[52], zero fill [55:53]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pwm_level[7:0], level_written[8], output_active[9],
                                   // zero fill [15:10]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [41:0] cfg_data
);

    spf_pkg::cfg_t     cfg_reg, cfg_next;
    spf_pkg::item_t    item;
    spf_pkg::res_t     seq_res;
    spf_pkg::div_req_t div_req;
    spf_pkg::div_rsp_t div_rsp;
    logic              cfg_wr;
    logic              suspend_wr;
    logic              seq_ready;
    logic              out_free;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [15:0]       m_tdata_reg, m_tdata_next;

    assign cfg_ready  = 1'b1;
    assign cfg_wr     = cfg_valid && cfg_ready;
    assign suspend_wr = cfg_wr && (cfg_index == spf_pkg::REG_SUSPEND);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_index)
                spf_pkg::REG_DAYS_MASK:     cfg_next.days_mask     = cfg_data[6:0];
                spf_pkg::REG_EVENT_COUNT:   cfg_next.event_count   = cfg_data[2:0];
                spf_pkg::REG_HAS_DEPENDENT: cfg_next.has_dependent = cfg_data[0];
                spf_pkg::REG_SUSPEND:       cfg_next.suspend       = cfg_data[0];
                spf_pkg::REG_EVENT_0:       cfg_next.events[0]     = cfg_data;
                spf_pkg::REG_EVENT_1:       cfg_next.events[1]     = cfg_data;
                spf_pkg::REG_EVENT_2:       cfg_next.events[2]     = cfg_data;
                spf_pkg::REG_EVENT_3:       cfg_next.events[3]     = cfg_data;
                default:                    cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign item.weekday      = s_tdata[2:0];
    assign item.time_of_day  = s_tdata[19:3];
    assign item.millis_now   = s_tdata[51:20];
    assign item.dependent_on = s_tdata[52];

    assign s_tready = seq_ready;
    assign out_free = !m_tvalid_reg || m_tready;

    spf_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .suspend_wr (suspend_wr),
        .start      (s_tvalid && seq_ready),
        .item       (item),
        .ready      (seq_ready),
        .out_free   (out_free),
        .res        (seq_res),
        .div_req    (div_req),
        .div_rsp    (div_rsp)
    );

    spf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (seq_res.valid)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'd0, seq_res.output_active, seq_res.level_written,
                             seq_res.pwm_level};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`include "scheduled_pwm_fader_assert.svh"

    `SPF_ASSERT_NXT(a_busy_after_request, s_tvalid && s_tready, !s_tready)
    `SPF_ASSERT_IMP(a_result_slot_free, seq_res.valid, !m_tvalid_reg || m_tready)
    `SPF_ASSERT_IMP(a_divider_idle_on_start, div_req.start, !div_rsp.busy)

endmodule

### hdl/spf_div.sv
// Shared restoring divider for the scheduled PWM fader, one quotient bit per cycle.
// Depends on spf_pkg for widths and the request and response structs.
module spf_div (
    input  logic              clk,
    input  logic              rst_n,
    input  spf_pkg::div_req_t req,
    output spf_pkg::div_rsp_t rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [spf_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [spf_pkg::DIVISOR_W-1:0]     rem_reg, rem_next;
    logic [spf_pkg::DIVIDEND_W-1:0]    quo_reg, quo_next;
    logic [spf_pkg::DIVISOR_W-1:0]     dvs_reg, dvs_next;
    logic [spf_pkg::DIVISOR_W:0]       shifted;
    logic                              fits;

    assign shifted = {rem_reg, quo_reg[spf_pkg::DIVIDEND_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits back in 28 bits.
            rem_next = fits ? spf_pkg::DIVISOR_W'(shifted - {1'b0, dvs_reg})
                            : shifted[spf_pkg::DIVISOR_W-1:0];
            quo_next = {quo_reg[spf_pkg::DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == spf_pkg::DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### hdl/spf_seq.sv
// Event sequencer of the scheduled PWM fader: holds the fade state and walks the
// events one at a time, using spf_div for both divisions. Depends on spf_pkg.
module spf_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  spf_pkg::cfg_t     cfg,
    input  logic              suspend_wr,
    input  logic              start,
    input  spf_pkg::item_t    item,
    output logic              ready,
    input  logic              out_free,
    output spf_pkg::res_t     res,
    output spf_pkg::div_req_t div_req,
    input  spf_pkg::div_rsp_t div_rsp
);

    spf_pkg::state_t               state_reg, state_next;
    logic [spf_pkg::EV_IDX_W-1:0]  idx_reg, idx_next;
    logic [16:0]                   now_reg, now_next;
    logic [31:0]                   ms_reg, ms_next;
    logic [7:0]                    level_reg, level_next;
    logic [7:0]                    fsl_reg, fsl_next;
    logic                          armed_reg, armed_next;
    logic [31:0]                   step_reg, step_next;
    logic [31:0]                   origin_reg, origin_next;
    logic                          active_reg, active_next;
    logic [7:0]                    pin_reg, pin_next;
    logic                          wrote_reg, wrote_next;
    logic [spf_pkg::DIVISOR_W-1:0] span_reg, span_next;
    logic [7:0]                    mag_reg, mag_next;
    logic                          neg_reg, neg_next;
    logic [spf_pkg::DIVISOR_W-1:0] intv_reg, intv_next;
    logic [spf_pkg::DIVISOR_W-1:0] e_reg, e_next;

    logic [spf_pkg::EV_CNT_W-1:0]  n_ev;
    logic [7:0]                    days_ext;
    logic [spf_pkg::EVENT_W-1:0]   ev;
    logic [16:0]                   ev_start;
    logic [16:0]                   ev_dur;
    logic [7:0]                    ev_tgt;
    logic [17:0]                   end_sum;
    logic [17:0]                   end_s;
    logic [17:0]                   win_len;
    logic [spf_pkg::DIVISOR_W-1:0] span_c;
    logic                          arm;
    logic                          armed_eff;
    logic                          in_win;
    logic                          at_end;
    logic                          tgt_below;
    logic [7:0]                    mag_c;
    logic [31:0]                   since_step;
    logic [31:0]                   elapsed;
    logic [7:0]                    q;
    logic                          last_ev;

    assign n_ev = (cfg.event_count > spf_pkg::EV_CNT_W'(spf_pkg::MAX_EVENTS))
                ? spf_pkg::EV_CNT_W'(spf_pkg::MAX_EVENTS) : cfg.event_count;
    assign days_ext = {1'b0, cfg.days_mask};
    assign last_ev  = ({1'b0, idx_reg} + 1'b1) == n_ev;

    // Event decode and window arithmetic for the event under evaluation.
    assign ev        = cfg.events[idx_reg];
    assign ev_start  = ev[16:0];
    assign ev_dur    = ev[33:17];
    assign ev_tgt    = ev[41:34];
    assign end_sum   = {1'b0, ev_start} + {1'b0, ev_dur};
    assign end_s     = (end_sum > spf_pkg::DAY_SECONDS) ? end_sum - spf_pkg::DAY_SECONDS
                                                         : end_sum;
    assign win_len   = end_s - {1'b0, ev_start};
    assign span_c    = {10'd0, win_len} * {18'd0, spf_pkg::MS_PER_S};
    assign arm       = (now_reg == ev_start) && !armed_reg;
    assign armed_eff = armed_reg || arm;
    assign in_win    = (now_reg >= ev_start) && ({1'b0, now_reg} < end_s);
    assign at_end    = {1'b0, now_reg} == end_s;
    assign tgt_below = ev_tgt < fsl_reg;
    assign mag_c     = tgt_below ? fsl_reg - ev_tgt : ev_tgt - fsl_reg;

    assign since_step = ms_reg - step_reg;
    assign elapsed    = ms_reg - origin_reg;
    assign q          = div_rsp.quotient[7:0];

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        now_next    = now_reg;
        ms_next     = ms_reg;
        level_next  = level_reg;
        fsl_next    = fsl_reg;
        armed_next  = armed_reg;
        step_next   = step_reg;
        origin_next = origin_reg;
        active_next = active_reg;
        pin_next    = pin_reg;
        wrote_next  = wrote_reg;
        span_next   = span_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        intv_next   = intv_reg;
        e_next      = e_reg;
        div_req     = '0;
        res         = '0;
        ready       = 1'b0;

        if (suspend_wr)
        begin
            pin_next = level_reg;
        end

        case (state_reg)
            spf_pkg::ST_IDLE:
            begin
                ready = 1'b1;
                if (start)
                begin
                    now_next   = item.time_of_day;
                    ms_next    = item.millis_now;
                    wrote_next = 1'b0;
                    idx_next   = '0;
                    state_next = spf_pkg::ST_DONE;
                    if (!cfg.suspend)
                    begin
                        if (n_ev == '0 && cfg.has_dependent)
                        begin
                            pin_next    = item.dependent_on ? spf_pkg::LEVEL_MAX : 8'd0;
                            active_next = item.dependent_on;
                            wrote_next  = 1'b1;
                        end
                        else if (n_ev != '0 && !cfg.has_dependent
                                 && days_ext[item.weekday])
                        begin
                            state_next = spf_pkg::ST_EVAL;
                        end
                    end
                end
            end

            spf_pkg::ST_EVAL:
            begin
                active_next = level_reg != 8'd0;
                if (arm)
                begin
                    armed_next  = 1'b1;
                    step_next   = ms_reg;
                    origin_next = ms_reg;
                end
                state_next = last_ev ? spf_pkg::ST_DONE : spf_pkg::ST_EVAL;
                idx_next   = last_ev ? idx_reg : idx_reg + 1'b1;
                if (in_win && armed_eff)
                begin
                    if (mag_c != 8'd0)
                    begin
                        span_next        = span_c;
                        mag_next         = mag_c;
                        neg_next         = tgt_below;
                        div_req.start    = 1'b1;
                        div_req.dividend = {8'd0, span_c};
                        div_req.divisor  = {20'd0, mag_c};
                        idx_next         = idx_reg;
                        state_next       = spf_pkg::ST_DIV_INT;
                    end
                end
                else if (at_end && armed_eff)
                begin
                    level_next = ev_tgt;
                    fsl_next   = ev_tgt;
                    pin_next   = ev_tgt;
                    wrote_next = 1'b1;
                    armed_next = 1'b0;
                end
            end

            spf_pkg::ST_DIV_INT:
            begin
                if (div_rsp.done)
                begin
                    intv_next  = div_rsp.quotient[spf_pkg::DIVISOR_W-1:0];
                    state_next = spf_pkg::ST_CHECK;
                end
            end

            spf_pkg::ST_CHECK:
            begin
                state_next = last_ev ? spf_pkg::ST_DONE : spf_pkg::ST_EVAL;
                idx_next   = last_ev ? idx_reg : idx_reg + 1'b1;
                if (since_step >= {4'd0, intv_reg})
                begin
                    e_next = elapsed[spf_pkg::DIVISOR_W-1:0];
                    if (elapsed <= {4'd0, span_reg})
                    begin
                        idx_next   = idx_reg;
                        state_next = spf_pkg::ST_MUL;
                    end
                    else
                    begin
                        // Past the end of the span: re-drive the level unchanged.
                        pin_next   = level_reg;
                        wrote_next = 1'b1;
                        step_next  = step_reg + {4'd0, intv_reg};
                    end
                end
            end

            spf_pkg::ST_MUL:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = mag_reg * e_reg;
                div_req.divisor  = span_reg;
                state_next       = spf_pkg::ST_DIV_LVL;
            end

            spf_pkg::ST_DIV_LVL:
            begin
                if (div_rsp.done)
                begin
                    // The quotient never exceeds the level difference, so the
                    // sum stays within the level range.
                    level_next = neg_reg ? fsl_reg - q : fsl_reg + q;
                    pin_next   = neg_reg ? fsl_reg - q : fsl_reg + q;
                    wrote_next = 1'b1;
                    step_next  = step_reg + {4'd0, intv_reg};
                    state_next = last_ev ? spf_pkg::ST_DONE : spf_pkg::ST_EVAL;
                    idx_next   = last_ev ? idx_reg : idx_reg + 1'b1;
                end
            end

            spf_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    res.valid         = 1'b1;
                    res.pwm_level     = pin_reg;
                    res.level_written = wrote_reg;
                    res.output_active = active_reg;
                    state_next        = spf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = spf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= spf_pkg::ST_IDLE;
            idx_reg    <= '0;
            level_reg  <= '0;
            fsl_reg    <= '0;
            armed_reg  <= 1'b0;
            step_reg   <= '0;
            origin_reg <= '0;
            active_reg <= 1'b0;
            pin_reg    <= '0;
            wrote_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            level_reg  <= level_next;
            fsl_reg    <= fsl_next;
            armed_reg  <= armed_next;
            step_reg   <= step_next;
            origin_reg <= origin_next;
            active_reg <= active_next;
            pin_reg    <= pin_next;
            wrote_reg  <= wrote_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg  <= now_next;
        ms_reg   <= ms_next;
        span_reg <= span_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        intv_reg <= intv_next;
        e_reg    <= e_next;
    end

endmodule
